>>> hw/rtl/sbt_pkg.sv
// Shared constants and byte classification helpers for the source byte tokeniser.
// Holds the token kind, operator and error codes and the keyword table.
// Depends on nothing; imported by source_byte_tokenizer.
package sbt_pkg;

  // Default sizes handed to the top level.
  localparam int MAX_TEXT_DEFAULT    = 123;
  localparam int OFFSET_BITS_DEFAULT = 32;
  localparam int LINE_BITS_DEFAULT   = 16;

  // Configuration register width and reset value.
  localparam int              CFG_BITS  = 7;
  localparam logic [CFG_BITS-1:0] CFG_RESET = 7'd123;

  // Token kinds.
  localparam logic [4:0] KIND_PRINT     = 5'd0;
  localparam logic [4:0] KIND_PRINTLN   = 5'd1;
  localparam logic [4:0] KIND_IDENT     = 5'd2;
  localparam logic [4:0] KIND_IF        = 5'd3;
  localparam logic [4:0] KIND_ELSE      = 5'd4;
  localparam logic [4:0] KIND_WHILE     = 5'd5;
  localparam logic [4:0] KIND_FOR       = 5'd6;
  localparam logic [4:0] KIND_BEGIN     = 5'd7;
  localparam logic [4:0] KIND_END_BRACE = 5'd8;
  localparam logic [4:0] KIND_TRIM      = 5'd9;
  localparam logic [4:0] KIND_TRIM_LINE = 5'd10;
  localparam logic [4:0] KIND_OPERATOR  = 5'd11;
  localparam logic [4:0] KIND_COMMA     = 5'd12;
  localparam logic [4:0] KIND_SEMICOLON = 5'd13;
  localparam logic [4:0] KIND_DQ_STRING = 5'd14;
  localparam logic [4:0] KIND_SQ_STRING = 5'd15;
  localparam logic [4:0] KIND_NUMBER    = 5'd16;
  localparam logic [4:0] KIND_RAW       = 5'd17;
  localparam logic [4:0] KIND_EOS       = 5'd18;

  // Operator codes.
  localparam logic [3:0] OP_PLUS    = 4'd0;
  localparam logic [3:0] OP_MINUS   = 4'd1;
  localparam logic [3:0] OP_TIMES   = 4'd2;
  localparam logic [3:0] OP_DIVIDE  = 4'd3;
  localparam logic [3:0] OP_POWER   = 4'd4;
  localparam logic [3:0] OP_LESS    = 4'd5;
  localparam logic [3:0] OP_GREATER = 4'd6;
  localparam logic [3:0] OP_EQUAL   = 4'd7;
  localparam logic [3:0] OP_OPEN    = 4'd8;
  localparam logic [3:0] OP_CLOSE   = 4'd9;
  localparam logic [3:0] OP_DOT     = 4'd10;

  // Error codes.
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_UNTERM     = 2'd1;
  localparam logic [1:0] ERR_TOO_LONG   = 2'd2;

  // Keyword table: _, __, if, else, while, for, each padded with zeros.
  localparam int KW_COUNT = 6;
  localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
    '{8'h5F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h5F, 8'h5F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65, 8'h00, 8'h00, 8'h00},
    '{8'h66, 8'h6F, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [7:0] KW_LEN  [KW_COUNT] = '{8'd1, 8'd2, 8'd2, 8'd4, 8'd5, 8'd3};
  localparam logic [4:0] KW_KIND [KW_COUNT] = '{KIND_PRINT, KIND_PRINTLN, KIND_IF,
                                               KIND_ELSE, KIND_WHILE, KIND_FOR};

  // Byte classes.
  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
  endfunction

  // Keyword candidates that survive byte c at text position pos.
  function automatic logic [KW_COUNT-1:0] kw_keep(input logic [7:0] c,
                                                  input logic [7:0] pos);
    logic [KW_COUNT-1:0] keep;
    keep = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (pos < KW_LEN[k]) begin
        keep[k] = (KW_TEXT[k][pos[2:0]] == c);
      end
    end
    return keep;
  endfunction

endpackage

>>> hw/rtl/source_byte_tokenizer.sv
// Top level of the source byte tokeniser: scanner state, token building and result queue.
// Depends on sbt_pkg for token codes, the keyword table and byte classes.
//
// The tokeniser takes one source byte per beat and returns token descriptors (kind,
// operator, raw byte, start offset, length, line and column, error). Each input beat
// is worked in the cycle it is accepted: short classification logic updates the scan
// state and writes zero, one or two descriptors into a four-entry result queue, which
// feeds the output one beat per cycle while out_ready is high. A descriptor is offered
// once it reaches the queue head. in_ready is high whenever the queue has room for two
// descriptors, so a new byte can be taken every cycle while the output keeps up. A
// single-byte token or end marker that also ends a pending token costs two output
// beats, so the sustained rate is one byte per cycle while each byte yields at most one
// descriptor, and one descriptor per cycle otherwise, set by the single-beat output
// port. The end marker flushes any pending token, emits an end token and returns the
// scan state to its reset values; max_token_length keeps its value.
module source_byte_tokenizer
  import sbt_pkg::*;
#(
  parameter int MAX_TEXT    = MAX_TEXT_DEFAULT,
  parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT,
  parameter int LINE_BITS   = LINE_BITS_DEFAULT,
  localparam int LEN_BITS   = $clog2(MAX_TEXT + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration
  input  logic                   write_enable,
  input  logic [CFG_BITS-1:0]    write_data,
  // Source bytes
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             source_byte,
  input  logic                   end_of_source,
  // Token descriptors
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [4:0]             token_kind,
  output logic [3:0]             operator_code,
  output logic [7:0]             raw_byte,
  output logic [OFFSET_BITS-1:0] start_offset,
  output logic [LEN_BITS-1:0]    text_length,
  output logic [LINE_BITS-1:0]   start_line,
  output logic [LINE_BITS-1:0]   start_column,
  output logic [1:0]             error_code,
  output logic                   last_of_run
);

  localparam int EW          = (LEN_BITS > CFG_BITS) ? LEN_BITS : CFG_BITS;
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_BITS    = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS    = $clog2(FIFO_DEPTH + 1);

  // Scan modes.
  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_IDENT  = 3'd1;
  localparam logic [2:0] MODE_NUMBER = 3'd2;
  localparam logic [2:0] MODE_SPACE  = 3'd3;
  localparam logic [2:0] MODE_DQ     = 3'd4;
  localparam logic [2:0] MODE_SQ     = 3'd5;

  localparam logic [7:0] CH_NL = 8'h0A;

  typedef struct packed {
    logic [4:0]             kind;
    logic [3:0]             op;
    logic [7:0]             raw;
    logic [OFFSET_BITS-1:0] start;
    logic [LEN_BITS-1:0]    len;
    logic [LINE_BITS-1:0]   line;
    logic [LINE_BITS-1:0]   col;
    logic [1:0]             err;
    logic                   last;
  } tok_t;

  // Configuration register.
  logic [CFG_BITS-1:0] max_token_length;

  // Scan state.
  logic [2:0]             mode, mode_next;
  logic                   run_nl, run_nl_next;
  logic [KW_COUNT-1:0]    kw, kw_next;
  logic [OFFSET_BITS-1:0] pstart, pstart_next;
  logic [LEN_BITS-1:0]    plen, plen_next;
  logic                   ptoo, ptoo_next;
  logic [OFFSET_BITS-1:0] offset, offset_next;
  logic [LINE_BITS-1:0]   line_cnt, line_cnt_next;
  logic [LINE_BITS-1:0]   col_cnt, col_cnt_next;
  logic [LINE_BITS-1:0]   pline, pline_next;
  logic [LINE_BITS-1:0]   pcol, pcol_next;

  // Result queue.
  tok_t                fifo [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] count;

  logic       accept, pop;
  logic       flush_v, single_v;
  tok_t       flush_tok, single_tok;
  tok_t       slot0, slot1;
  logic [1:0] n_push;

  logic [EW-1:0] eff_limit;
  logic          is_quote_close;

  assign accept = in_valid && in_ready;
  assign pop    = out_valid && out_ready;

  // Effective length limit: the register, capped by the text counter's range.
  assign eff_limit = (EW'(max_token_length) < EW'(MAX_TEXT)) ? EW'(max_token_length)
                                                            : EW'(MAX_TEXT);

  assign is_quote_close = (mode == MODE_DQ) ? (source_byte == 8'h22)
                                            : (source_byte == 8'h27);

  // Token building and scan state update for one accepted beat.
  always_comb begin
    logic [4:0] fl_kind;
    logic [1:0] fl_err;
    logic       do_append;
    logic       do_flush;

    mode_next     = mode;
    run_nl_next   = run_nl;
    kw_next       = kw;
    pstart_next   = pstart;
    plen_next     = plen;
    ptoo_next     = ptoo;
    offset_next   = offset + OFFSET_BITS'(1);
    line_cnt_next = line_cnt;
    col_cnt_next  = col_cnt;
    pline_next    = pline;
    pcol_next     = pcol;
    single_v      = 1'b0;
    single_tok    = '0;
    do_append     = 1'b0;
    do_flush      = 1'b0;
    fl_err        = ERR_NONE;

    // Kind of the pending token, should it be flushed.
    fl_kind = KIND_IDENT;
    unique case (mode)
      MODE_IDENT: begin
        for (int k = 0; k < KW_COUNT; k++) begin
          if (kw[k] && 8'(plen) == KW_LEN[k]) begin
            fl_kind = KW_KIND[k];
          end
        end
      end
      MODE_NUMBER: fl_kind = KIND_NUMBER;
      MODE_SPACE:  fl_kind = run_nl ? KIND_TRIM_LINE : KIND_TRIM;
      MODE_DQ:     fl_kind = KIND_DQ_STRING;
      MODE_SQ:     fl_kind = KIND_SQ_STRING;
      default:     fl_kind = KIND_IDENT;
    endcase

    // Position advance: a newline bumps the line and restarts the column.
    if (source_byte == CH_NL) begin
      if (line_cnt != '1) begin
        line_cnt_next = line_cnt + LINE_BITS'(1);
      end
      col_cnt_next = '0;
    end else if (col_cnt != '1) begin
      col_cnt_next = col_cnt + LINE_BITS'(1);
    end

    if (end_of_source) begin
      // Flush whatever is pending, then the end token; scan state returns to reset.
      do_flush   = (mode != MODE_IDLE);
      fl_err     = (mode == MODE_DQ || mode == MODE_SQ) ? ERR_UNTERM : ERR_NONE;
      single_v   = 1'b1;
      single_tok = '{kind: KIND_EOS, op: '0, raw: '0, start: offset, len: '0,
                     line: line_cnt, col: col_cnt, err: ERR_NONE, last: 1'b0};
      mode_next     = MODE_IDLE;
      run_nl_next   = 1'b0;
      kw_next       = '1;
      pstart_next   = '0;
      plen_next     = '0;
      ptoo_next     = 1'b0;
      offset_next   = '0;
      line_cnt_next = '0;
      col_cnt_next  = '0;
      pline_next    = '0;
      pcol_next     = '0;
    end else if (mode == MODE_DQ || mode == MODE_SQ) begin
      // Inside a string every byte is text until the matching quote.
      if (is_quote_close) begin
        do_flush = 1'b1;
      end else begin
        do_append = 1'b1;
      end
    end else if ((mode == MODE_IDENT && (is_alpha(source_byte) || is_digit(source_byte)))
                 || (mode == MODE_NUMBER && is_digit(source_byte))) begin
      do_append = 1'b1;
    end else if (mode == MODE_SPACE && is_space(source_byte)) begin
      do_append = 1'b1;
      if (source_byte == CH_NL) begin
        run_nl_next = 1'b1;
      end
    end else begin
      // The byte ends any pending token and starts something new.
      do_flush = (mode != MODE_IDLE);
      priority if (is_space(source_byte) || is_alpha(source_byte)
                   || is_digit(source_byte)) begin
        mode_next   = is_space(source_byte) ? MODE_SPACE
                    : (is_alpha(source_byte) ? MODE_IDENT : MODE_NUMBER);
        pstart_next = offset;
        plen_next   = LEN_BITS'(1);
        ptoo_next   = (eff_limit == '0);
        kw_next     = kw_keep(source_byte, 8'd0);
        run_nl_next = (source_byte == CH_NL);
        pline_next  = line_cnt;
        pcol_next   = col_cnt;
      end else if (source_byte == 8'h22 || source_byte == 8'h27) begin
        mode_next   = (source_byte == 8'h22) ? MODE_DQ : MODE_SQ;
        pstart_next = offset + OFFSET_BITS'(1);
        plen_next   = '0;
        ptoo_next   = 1'b0;
        kw_next     = '1;
        run_nl_next = 1'b0;
        pline_next  = line_cnt;
        pcol_next   = col_cnt;
      end else begin
        // Single-byte tokens; form feed and vertical tab make nothing.
        if (do_flush) begin
          mode_next = MODE_IDLE;
        end
        single_v   = 1'b1;
        single_tok = '{kind: KIND_OPERATOR, op: '0, raw: '0, start: offset,
                       len: LEN_BITS'(1), line: line_cnt, col: col_cnt,
                       err: (eff_limit == '0) ? ERR_TOO_LONG : ERR_NONE, last: 1'b0};
        unique case (source_byte)
          8'h0C, 8'h0B: single_v = 1'b0;
          8'h2B: single_tok.op = OP_PLUS;
          8'h2D: single_tok.op = OP_MINUS;
          8'h2A: single_tok.op = OP_TIMES;
          8'h2F: single_tok.op = OP_DIVIDE;
          8'h5E: single_tok.op = OP_POWER;
          8'h3C: single_tok.op = OP_LESS;
          8'h3E: single_tok.op = OP_GREATER;
          8'h3D: single_tok.op = OP_EQUAL;
          8'h28: single_tok.op = OP_OPEN;
          8'h29: single_tok.op = OP_CLOSE;
          8'h2E: single_tok.op = OP_DOT;
          8'h2C: single_tok.kind = KIND_COMMA;
          8'h3B: single_tok.kind = KIND_SEMICOLON;
          8'h7B: single_tok.kind = KIND_BEGIN;
          8'h7D: single_tok.kind = KIND_END_BRACE;
          default: begin
            single_tok.kind = KIND_RAW;
            single_tok.raw  = source_byte;
          end
        endcase
      end
    end

    // A string closed by its quote returns to idle.
    if (!end_of_source && (mode == MODE_DQ || mode == MODE_SQ) && is_quote_close) begin
      mode_next = MODE_IDLE;
    end

    // Append the byte to the pending token.
    if (do_append) begin
      kw_next = kw & kw_keep(source_byte, 8'(plen));
      if (EW'(plen) >= eff_limit) begin
        ptoo_next = 1'b1;
      end
      if (plen < LEN_BITS'(MAX_TEXT)) begin
        plen_next = plen + LEN_BITS'(1);
      end
    end

    flush_v   = do_flush;
    flush_tok = '{kind: fl_kind, op: '0, raw: '0, start: pstart, len: plen,
                  line: pline, col: pcol,
                  err: (fl_err == ERR_NONE && ptoo) ? ERR_TOO_LONG : fl_err,
                  last: 1'b0};
  end

  // Order the results: a flushed token always goes first; the last one is marked.
  always_comb begin
    slot0  = flush_v ? flush_tok : single_tok;
    slot1  = single_tok;
    n_push = 2'(flush_v) + 2'(single_v);
    if (n_push == 2'd2) begin
      slot1.last = 1'b1;
    end else begin
      slot0.last = 1'b1;
    end
  end

  // Room for two results means any byte can be taken.
  assign in_ready  = (count <= CNT_BITS'(FIFO_DEPTH - 2));
  assign out_valid = (count != '0);

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_token_length <= CFG_RESET;
      mode     <= MODE_IDLE;
      run_nl   <= 1'b0;
      kw       <= '1;
      pstart   <= '0;
      plen     <= '0;
      ptoo     <= 1'b0;
      offset   <= '0;
      line_cnt <= '0;
      col_cnt  <= '0;
      pline    <= '0;
      pcol     <= '0;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
    end else begin
      if (write_enable) begin
        max_token_length <= write_data;
      end
      if (accept) begin
        mode     <= mode_next;
        run_nl   <= run_nl_next;
        kw       <= kw_next;
        pstart   <= pstart_next;
        plen     <= plen_next;
        ptoo     <= ptoo_next;
        offset   <= offset_next;
        line_cnt <= line_cnt_next;
        col_cnt  <= col_cnt_next;
        pline    <= pline_next;
        pcol     <= pcol_next;
        wr_ptr   <= wr_ptr + PTR_BITS'(n_push);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      count <= count + (accept ? CNT_BITS'(n_push) : '0) - CNT_BITS'(pop);
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (accept && n_push != 2'd0) begin
      fifo[wr_ptr] <= slot0;
    end
    if (accept && n_push == 2'd2) begin
      fifo[wr_ptr + PTR_BITS'(1)] <= slot1;
    end
  end

  // Output beat from the head of the queue.
  assign token_kind    = fifo[rd_ptr].kind;
  assign operator_code = fifo[rd_ptr].op;
  assign raw_byte      = fifo[rd_ptr].raw;
  assign start_offset  = fifo[rd_ptr].start;
  assign text_length   = fifo[rd_ptr].len;
  assign start_line    = fifo[rd_ptr].line;
  assign start_column  = fifo[rd_ptr].col;
  assign error_code    = fifo[rd_ptr].err;
  assign last_of_run   = fifo[rd_ptr].last;

endmodule
